// File: hw/rtl/longest_increasing_subsequence_top_defines.svh
// ----------------------------------------------------------------------------
// longest increasing subsequence - assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef LONGEST_INCREASING_SUBSEQUENCE_TOP_DEFINES_SVH
`define LONGEST_INCREASING_SUBSEQUENCE_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define LIS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define LIS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/lis_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lis_pkg
// shared constants and controller/datapath interface types
// ----------------------------------------------------------------------------
package lis_pkg;

  localparam int DEPTH_DEF  = 1024;
  localparam int VALUE_W    = 32;
  localparam int IN_TDATA_W = 32;

  // commands from controller to datapath
  typedef struct packed {
    logic start;   // capture input transfer, set up search bounds
    logic search;  // one binary-search probe step
    logic update;  // write tails, update length, load output register
  } lis_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic search_done;
  } lis_stat_t;

endpackage

// File: hw/rtl/lis_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lis_ctrl
// sequencer: accept, binary search, update, and output register handshake
// ----------------------------------------------------------------------------
module lis_ctrl
  import lis_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  output logic      out_tvalid,
  input  logic      out_tready,
  output lis_cmd_t  cmd,
  input  lis_stat_t stat
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_UPDATE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  // output register can take a new result
  assign slot_free = !out_valid_r || out_tready;

  // command decode
  always_comb begin
    cmd        = '0;
    cmd.start  = (state_r == S_IDLE) && in_tvalid;
    cmd.search = (state_r == S_SEARCH);
    cmd.update = (state_r == S_UPDATE) && slot_free;
  end

  // next state
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (stat.search_done) begin
          state_nxt = S_UPDATE;
        end
      end
      S_UPDATE: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

endmodule

// File: hw/rtl/lis_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lis_dp
// tails memory, binary-search bounds, run length and output payload
// ----------------------------------------------------------------------------
module lis_dp
  import lis_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  localparam int LW   = $clog2(DEPTH + 1),
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lis_cmd_t                   cmd,
  output lis_stat_t                  stat,
  input  logic signed [VALUE_W-1:0]  in_value,
  input  logic                       in_first,
  input  logic                       in_last,
  output logic        [LW-1:0]       out_length,
  output logic                       out_done,
  output logic                       out_overflow
);

  // tails store, one read and one write port
  logic [VALUE_W-1:0] tails_mem [DEPTH];
  logic [VALUE_W-1:0] rdata_r;

  logic signed [VALUE_W-1:0] value_r;
  logic                      last_r;
  logic [LW-1:0]             run_len_r;
  logic                      ovf_r;
  logic [LW-1:0]             lo_r, hi_r, mid_r;
  logic                      pend_r;
  logic [LW-1:0]             out_len_r;
  logic                      out_last_r, out_ovf_r;

  logic                      ge;
  logic [LW-1:0]             eff_lo, eff_hi, mid_nxt;
  logic                      busy;
  logic                      wr_en;
  logic [LW-1:0]             wr_idx, len_nxt;
  logic                      ovf_nxt;

  // fold in the probe that returned this cycle, then pick the next midpoint
  always_comb begin
    ge      = $signed(rdata_r) >= value_r;
    eff_lo  = (pend_r && !ge) ? (mid_r + LW'(1)) : lo_r;
    eff_hi  = (pend_r && ge) ? mid_r : hi_r;
    busy    = eff_lo < eff_hi;
    mid_nxt = eff_lo + ((eff_hi - eff_lo) >> 1);
  end

  assign stat.search_done = !busy;

  // replace, append or drop once the slot is known
  always_comb begin
    wr_en   = 1'b0;
    wr_idx  = lo_r;
    len_nxt = run_len_r;
    ovf_nxt = ovf_r;
    if (lo_r < run_len_r) begin
      wr_en = 1'b1;
    end else if (run_len_r < LW'(DEPTH)) begin
      wr_en   = 1'b1;
      wr_idx  = run_len_r;
      len_nxt = run_len_r + LW'(1);
    end else begin
      ovf_nxt = 1'b1;
    end
  end

  // memory ports
  always_ff @(posedge clk) begin
    if (cmd.search && busy) begin
      rdata_r <= tails_mem[mid_nxt[AW-1:0]];
    end
    if (cmd.update && wr_en) begin
      tails_mem[wr_idx[AW-1:0]] <= value_r;
    end
  end

  // sequence state and search control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_len_r <= '0;
      ovf_r     <= 1'b0;
      pend_r    <= 1'b0;
    end else if (cmd.start) begin
      pend_r <= 1'b0;
      if (in_first) begin
        run_len_r <= '0;
        ovf_r     <= 1'b0;
      end
    end else if (cmd.search) begin
      pend_r <= busy;
    end else if (cmd.update) begin
      run_len_r <= len_nxt;
      ovf_r     <= ovf_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      value_r <= in_value;
      last_r  <= in_last;
      lo_r    <= '0;
      hi_r    <= in_first ? '0 : run_len_r;
    end else if (cmd.search) begin
      lo_r  <= eff_lo;
      hi_r  <= eff_hi;
      mid_r <= mid_nxt;
    end
    if (cmd.update) begin
      out_len_r  <= len_nxt;
      out_last_r <= last_r;
      out_ovf_r  <= ovf_nxt;
    end
  end

  assign out_length   = out_len_r;
  assign out_done     = out_last_r;
  assign out_overflow = out_ovf_r;

endmodule

// File: hw/rtl/longest_increasing_subsequence_top.sv
`timescale 1ns / 1ps
// Per item: the input transfer is captured, the binary search probes the tails
// over L, the run length before the item (0 with first), and the update writes
// the tails and loads the result once the output register is free. Items
// go one at a time; the single tails read port allows one search probe a cycle.
// Reset clears run length, overflow flag and handshakes at once; the tails
// memory is not cleared, so the block is ready right after reset.
// ----------------------------------------------------------------------------
// longest_increasing_subsequence_top
// streaming longest strictly increasing subsequence length, patience sorting
// ----------------------------------------------------------------------------
module longest_increasing_subsequence_top
  import lis_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  localparam int LW        = $clog2(DEPTH + 1),
  localparam int OUT_TDATA_W = ((LW + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [31:0] value
  input  logic                   in_tuser,   // first
  input  logic                   in_tlast,   // last
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [LW-1:0] length, zero fill above
  output logic                   out_tuser,  // overflow
  output logic                   out_tlast   // done_res
);

  lis_cmd_t      cmd;
  lis_stat_t     stat;
  logic [LW-1:0] length;

  lis_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .stat       (stat)
  );

  lis_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .in_value     ($signed(in_tdata[VALUE_W-1:0])),
    .in_first     (in_tuser),
    .in_last      (in_tlast),
    .out_length   (length),
    .out_done     (out_tlast),
    .out_overflow (out_tuser)
  );

  assign out_tdata = OUT_TDATA_W'(length);

endmodule

// File: hw/rtl/lis_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lis_checker
// port-level checks on the top level, attached by bind
// ----------------------------------------------------------------------------
`include "longest_increasing_subsequence_top_defines.svh"

module lis_prop_checker
  import lis_pkg::*;
#(
  parameter int DEPTH        = DEPTH_DEF,
  localparam int LW          = $clog2(DEPTH + 1),
  localparam int OUT_TDATA_W = ((LW + 7) / 8) * 8
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tuser
);

  // stalled result stays offered
  `LIS_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid, "out_tvalid dropped")

  // stalled result keeps its data
  `LIS_ASSERT_NEXT(a_out_stable, out_tvalid && !out_tready, $stable(out_tdata), "out_tdata moved")

  // overflow only ever reported with a full tails store
  `LIS_ASSERT_NOW(a_ovf_full, out_tvalid && out_tuser, out_tdata[LW-1:0] == LW'(DEPTH), "overflow below full")

  // one item at a time: input closes after a transfer
  `LIS_ASSERT_NEXT(a_one_item, in_tvalid && in_tready, !in_tready, "in_tready held after transfer")

endmodule

bind longest_increasing_subsequence_top lis_prop_checker #(.DEPTH(DEPTH)) u_lis_prop_checker (.*);
